// ----- rtl/cep_pkg.sv -----
// Shared types and constants of the category event prescaler.
`default_nettype none

package cep_pkg;

   localparam int PATTERN_WIDTH   = 16;
   localparam int FACTOR_WIDTH    = 24;
   localparam int SLOT_IDX_WIDTH  = 3;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 57;
   localparam int QUEUE_DEPTH     = 2;

   // One category slot, packed exactly as the configuration word.
   typedef struct packed {
      logic                     valid;
      logic [PATTERN_WIDTH-1:0] id;
      logic [PATTERN_WIDTH-1:0] mask;
      logic [FACTOR_WIDTH-1:0]  factor;
   } slot_type;

   // A classified event on its way from the front to the back.
   typedef struct packed {
      logic                      matched;
      logic [SLOT_IDX_WIDTH-1:0] slot;
      logic [PATTERN_WIDTH-1:0]  pattern;
      logic [FACTOR_WIDTH-1:0]   factor;
   } entry_type;

endpackage

`default_nettype wire

// ----- rtl/category_event_prescaler.sv -----
// Top level of the category event prescaler.
// Usage: each beat on the req_ channel carries one event's condition bits.
// The front end matches them against the configured category slots and
// picks the matching valid slot with the smallest identifier (lowest index
// on a tie). The back end bumps that slot's saturating counter and keeps the
// event when the count reaches the slot's prescale factor, clearing the count.
// Every event yields exactly one beat on the rsp_ channel, in order.
// Path: an accepted req_ beat is written into the queue; the back end moves it
// from the queue head into the result register, which drives rsp_. Throughput:
// one event per cycle while rsp_stall is low, set by the single counter
// read-modify-write per cycle in the back end. When the receiver raises
// rsp_stall, the result register holds its beat, the two-entry queue fills,
// and req_stall rises once the queue is full. The csr_ channel is always
// ready; a write to an index at or beyond the number of categories is dropped.
// Slots must be written by the user only while idle; the block does not check.
// Reset clears all slots (no category valid), all counters and the queue.
`default_nettype none

module category_event_prescaler #(
   parameter int NUM_CONDITIONS = 16,
   parameter int NUM_CATEGORIES = 8,
   parameter int COUNT_WIDTH    = 24
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [cep_pkg::PATTERN_WIDTH-1:0]     req_condition_bits,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_kept,
   output logic                                       rsp_matched,
   output logic [cep_pkg::SLOT_IDX_WIDTH-1:0]         rsp_winning_slot,
   output logic [cep_pkg::PATTERN_WIDTH-1:0]          rsp_event_pattern,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [cep_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [cep_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import cep_pkg::*;

   slot_type  slot_ff [NUM_CATEGORIES];
   slot_type  slot_in [NUM_CATEGORIES];

   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;
   logic      queue_full;

   // Configuration is always accepted; the data word maps directly onto
   // the slot layout.
   assign csr_ready = 1'b1;

   always_comb begin
      for (int i = 0; i < NUM_CATEGORIES; i++) begin
         slot_in[i] = slot_ff[i];
         if (csr_valid && csr_ready && (csr_index == CSR_INDEX_WIDTH'(i))) begin
            slot_in[i] = slot_type'(csr_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CATEGORIES; i++) begin
            slot_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NUM_CATEGORIES; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   // The front end classifies each event as it is accepted.
   cep_front #(
      .NUM_CONDITIONS (NUM_CONDITIONS),
      .NUM_CATEGORIES (NUM_CATEGORIES)
   ) u_front (
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_condition_bits (req_condition_bits),
      .slots              (slot_ff),
      .queue_full         (queue_full),
      .push               (push),
      .push_entry         (push_entry)
   );

   // The queue decouples the front end from stalls at the output.
   cep_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .full       (queue_full)
   );

   // The back end owns the counters and the output register.
   cep_back #(
      .NUM_CATEGORIES (NUM_CATEGORIES),
      .COUNT_WIDTH    (COUNT_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_entry        (head_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kept          (rsp_kept),
      .rsp_matched       (rsp_matched),
      .rsp_winning_slot  (rsp_winning_slot),
      .rsp_event_pattern (rsp_event_pattern)
   );

`ifndef NO_ASSERTIONS
   // An unmatched event can never be kept and always reports slot zero.
   a_unmatched_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_matched) |-> (!rsp_kept && (rsp_winning_slot == '0)))
      else $error("unmatched result is kept or names a slot");

   // A matched result always names a slot that takes part in matching. The
   // compare is one bit wider so that a full table of categories still fits.
   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_matched) |->
         ({1'b0, rsp_winning_slot} < (SLOT_IDX_WIDTH + 1)'(NUM_CATEGORIES)))
      else $error("winning slot beyond the category count");
`endif

endmodule

`default_nettype wire

// ----- rtl/cep_front.sv -----
// Front end: accepts events and finds the winning category slot.
`default_nettype none

module cep_front #(
   parameter int NUM_CONDITIONS = 16,
   parameter int NUM_CATEGORIES = 8
) (
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [cep_pkg::PATTERN_WIDTH-1:0]   req_condition_bits,
   input  wire cep_pkg::slot_type                   slots [NUM_CATEGORIES],
   input  wire logic                                queue_full,
   output logic                                     push,
   output cep_pkg::entry_type                       push_entry
);
   import cep_pkg::*;

   localparam logic [PATTERN_WIDTH-1:0] COND_MASK =
      PATTERN_WIDTH'((17'(1) << NUM_CONDITIONS) - 17'(1));

   logic [PATTERN_WIDTH-1:0]  pattern;
   logic                      found;
   logic [PATTERN_WIDTH-1:0]  best_id;
   logic [SLOT_IDX_WIDTH-1:0] best;
   logic [FACTOR_WIDTH-1:0]   best_factor;

   assign pattern = req_condition_bits & COND_MASK;

   // Walk the slots in index order; a strict compare keeps the lowest
   // index when several matching slots share the smallest identifier.
   always_comb begin
      found       = 1'b0;
      best_id     = '0;
      best        = '0;
      best_factor = '0;
      for (int i = 0; i < NUM_CATEGORIES; i++) begin
         if (slots[i].valid && ((pattern & slots[i].mask) == slots[i].id)) begin
            if (!found || (slots[i].id < best_id)) begin
               found       = 1'b1;
               best_id     = slots[i].id;
               best        = SLOT_IDX_WIDTH'(i);
               best_factor = slots[i].factor;
            end
         end
      end
   end

   assign req_stall          = queue_full;
   assign push               = req_valid && !queue_full;
   assign push_entry.matched = found;
   assign push_entry.slot    = best;
   assign push_entry.pattern = pattern;
   assign push_entry.factor  = best_factor;

endmodule

`default_nettype wire

// ----- rtl/cep_queue.sv -----
// Short queue of classified events between the front and the back.
`default_nettype none

module cep_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire cep_pkg::entry_type push_entry,
   input  wire logic               pop,
   output logic                    head_valid,
   output cep_pkg::entry_type      head_entry,
   output logic                    full
);
   import cep_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   assign head_valid = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];
   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// ----- rtl/cep_back.sv -----
// Back end: updates the winning slot's counter and holds the result beat.
`default_nettype none

module cep_back #(
   parameter int NUM_CATEGORIES = 8,
   parameter int COUNT_WIDTH    = 24
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 head_valid,
   input  wire cep_pkg::entry_type                   head_entry,
   output logic                                      pop,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_kept,
   output logic                                      rsp_matched,
   output logic [cep_pkg::SLOT_IDX_WIDTH-1:0]        rsp_winning_slot,
   output logic [cep_pkg::PATTERN_WIDTH-1:0]         rsp_event_pattern
);
   import cep_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic [COUNT_WIDTH-1:0] counter_ff [NUM_CATEGORIES];
   logic [COUNT_WIDTH-1:0] counter_in [NUM_CATEGORIES];

   logic                      rsp_valid_ff,   rsp_valid_in;
   logic                      rsp_kept_ff,    rsp_kept_in;
   logic                      rsp_matched_ff, rsp_matched_in;
   logic [SLOT_IDX_WIDTH-1:0] rsp_slot_ff,    rsp_slot_in;
   logic [PATTERN_WIDTH-1:0]  rsp_pattern_ff, rsp_pattern_in;

   logic                   advance;
   logic [COUNT_WIDTH-1:0] cur_count;
   logic [COUNT_WIDTH-1:0] inc_count;
   logic                   keep;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = head_valid && advance;

   // One-hot select of the winning slot's counter.
   always_comb begin
      cur_count = '0;
      for (int i = 0; i < NUM_CATEGORIES; i++) begin
         if (head_entry.slot == SLOT_IDX_WIDTH'(i)) begin
            cur_count = counter_ff[i];
         end
      end
   end

   assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_WIDTH'(1);
   assign keep      = head_entry.matched && (head_entry.factor != '0) &&
                      (FACTOR_WIDTH'(inc_count) >= head_entry.factor);

   always_comb begin
      for (int i = 0; i < NUM_CATEGORIES; i++) begin
         counter_in[i] = counter_ff[i];
         if (pop && head_entry.matched && (head_entry.slot == SLOT_IDX_WIDTH'(i))) begin
            counter_in[i] = keep ? '0 : inc_count;
         end
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_kept_in    = rsp_kept_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_pattern_in = rsp_pattern_ff;
      if (advance) begin
         rsp_valid_in = head_valid;
      end
      if (pop) begin
         rsp_kept_in    = keep;
         rsp_matched_in = head_entry.matched;
         rsp_slot_in    = head_entry.matched ? head_entry.slot : '0;
         rsp_pattern_in = head_entry.pattern;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CATEGORIES; i++) begin
            counter_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_CATEGORIES; i++) begin
            counter_ff[i] <= counter_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_kept_ff    <= rsp_kept_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_pattern_ff <= rsp_pattern_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kept          = rsp_kept_ff;
   assign rsp_matched       = rsp_matched_ff;
   assign rsp_winning_slot  = rsp_slot_ff;
   assign rsp_event_pattern = rsp_pattern_ff;

endmodule

`default_nettype wire
